@@ hdl/ihex_pkg.sv @@
// Shared constants, types and a helper function for the Intel HEX record parser.
package ihex_pkg;

  // Largest number of data bytes that one record may carry
  localparam int unsigned MAX_DATA_BYTES = 16;
  localparam int unsigned DIDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

  // Field widths fixed by the result format
  localparam int unsigned POS_W    = 6;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 160;

  // Characters with a meaning of their own
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_COLON = 8'h3a;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  // One finished record, address not yet adjusted for word mode
  typedef struct packed {
    logic [CNT_W-1:0]  data_count;
    logic [ADDR_W-1:0] load_address;
    logic [7:0]        record_type;
    logic [DATA_W-1:0] data_low;
    logic [DATA_W-1:0] data_high;
    logic              checksum_ok;
    logic              format_error;
  } ihex_res_t;

  // Decode one ASCII hex digit, either case
  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.val = 4'(c - 8'h57);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ hdl/intel_hex_record_parser_core.sv @@
// Intel HEX record parser top level: stream ports, word-mode register, result register.
// The result is registered: it appears on the master side in the cycle after the line feed is accepted.
// Throughput: one character per cycle; the result register frees itself the cycle it is taken.
// The slave side stalls only while a finished result waits and the master side is not ready.
// Reset: asynchronous active low; clears the record state, empties the result register
// and sets word address mode to 1.
module intel_hex_record_parser_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration: word_address_mode
  input  logic                                 cfg_we_i,
  input  logic [0:0]                           cfg_wdata_i,
  // slave side: [7:0] char_in
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [ihex_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // master side: [4:0] data_count, [20:5] load_address, [28:21] record_type,
  // [92:29] data_low, [156:93] data_high, [157] checksum_ok, [158] format_error,
  // [159] zero
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [ihex_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import ihex_pkg::*;

  logic                    word_mode_q;
  logic                    s_accept;
  logic                    res_valid;
  ihex_res_t               res;
  logic [ADDR_W-1:0]       addr_rep;
  logic                    out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0]  out_data_q, out_data_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Hold the word address mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      word_mode_q <= cfg_wdata_i[0];
    end
  end

  ihex_rec_asm u_asm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (s_accept),
    .char_i       (s_axis_tdata),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Load a finished record into the result register, drop it once taken
  always_comb begin
    addr_rep    = word_mode_q ? {1'b0, res.load_address[ADDR_W-1:1]} : res.load_address;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_data_d  = {1'b0, res.format_error, res.checksum_ok, res.data_high, res.data_low,
                     res.record_type, addr_rep, res.data_count};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A result only appears after an accepted line feed
  a_rise_after_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_accept && s_axis_tdata == CHAR_LF))
    else $error("result word without a line feed");

  // A record closed by a line feed always produces a word
  a_lf_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> m_axis_tvalid)
    else $error("closed record produced no word");

  // A held word is never overwritten while the master side stalls
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !res_valid)
    else $error("result register overwritten while stalled");

endmodule

@@ hdl/ihex_rec_asm.sv @@
// Record assembler: takes one character per cycle and builds the record fields.
module ihex_rec_asm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               char_valid_i,
  input  logic [7:0]         char_i,
  output logic               res_valid_o,
  output ihex_pkg::ihex_res_t res_o
);
  import ihex_pkg::*;

  logic                     in_rec_q, in_rec_d;
  logic [POS_W-1:0]         pos_q, pos_d;
  logic [3:0]               nib_q, nib_d;
  logic [7:0]               count_q, count_d;
  logic [ADDR_W-1:0]        addr_q, addr_d;
  logic [7:0]               type_q, type_d;
  logic [7:0]               data_q [MAX_DATA_BYTES];
  logic [7:0]               data_d [MAX_DATA_BYTES];
  logic [7:0]               sum_q, sum_d;
  logic [7:0]               chk_q, chk_d;
  logic                     err_q, err_d;

  hex_digit_t               hv;
  logic [CNT_W-1:0]         taken;
  logic [POS_W-1:0]         data_end;
  logic [POS_W-1:0]         rec_end;
  logic [7:0]               byte_w;
  logic [POS_W-1:0]         pos_off;
  logic [DIDX_W-1:0]        didx;
  logic [2*DATA_W-1:0]      packed_w;

  // Decode the character and the record geometry
  always_comb begin
    hv       = hex_value(char_i);
    taken    = (count_q > MAX_DATA_BYTES) ? CNT_W'(MAX_DATA_BYTES) : count_q[CNT_W-1:0];
    data_end = POS_W'(8) + POS_W'({taken, 1'b0});
    rec_end  = data_end + POS_W'(2);
    byte_w   = {nib_q, hv.val};
    pos_off  = pos_q - POS_W'(8);
    didx     = pos_off[DIDX_W:1];
  end

  // Advance the record state on each accepted character
  always_comb begin
    in_rec_d    = in_rec_q;
    pos_d       = pos_q;
    nib_d       = nib_q;
    count_d     = count_q;
    addr_d      = addr_q;
    type_d      = type_q;
    data_d      = data_q;
    sum_d       = sum_q;
    chk_d       = chk_q;
    err_d       = err_q;
    res_valid_o = 1'b0;
    if (char_valid_i) begin
      if (char_i == CHAR_COLON) begin
        // open a new record, drop whatever was in progress
        in_rec_d = 1'b1;
        pos_d    = '0;
        nib_d    = '0;
        count_d  = '0;
        addr_d   = '0;
        type_d   = '0;
        for (int i = 0; i < MAX_DATA_BYTES; i++) begin
          data_d[i] = '0;
        end
        sum_d    = '0;
        chk_d    = '0;
        err_d    = 1'b0;
      end else if (in_rec_q && char_i != CHAR_CR) begin
        if (char_i == CHAR_LF) begin
          in_rec_d    = 1'b0;
          res_valid_o = 1'b1;
        end else if (!hv.ok) begin
          err_d = 1'b1;
        end else if (pos_q < rec_end) begin
          pos_d = pos_q + POS_W'(1);
          if (!pos_q[0]) begin
            nib_d = hv.val;
          end else begin
            if (pos_q == POS_W'(1)) begin
              count_d = byte_w;
            end else if (pos_q == POS_W'(3)) begin
              addr_d = {byte_w, addr_q[7:0]};
            end else if (pos_q == POS_W'(5)) begin
              addr_d = {addr_q[15:8], byte_w};
            end else if (pos_q == POS_W'(7)) begin
              type_d = byte_w;
            end else if (pos_q < data_end) begin
              data_d[didx] = byte_w;
            end else begin
              chk_d = byte_w;
            end
            if (pos_q < data_end) begin
              sum_d = sum_q + byte_w;
            end
          end
        end
      end
    end
  end

  // Hold the record state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rec_q <= 1'b0;
      pos_q    <= '0;
      nib_q    <= '0;
      count_q  <= '0;
      addr_q   <= '0;
      type_q   <= '0;
      for (int i = 0; i < MAX_DATA_BYTES; i++) begin
        data_q[i] <= '0;
      end
      sum_q    <= '0;
      chk_q    <= '0;
      err_q    <= 1'b0;
    end else begin
      in_rec_q <= in_rec_d;
      pos_q    <= pos_d;
      nib_q    <= nib_d;
      count_q  <= count_d;
      addr_q   <= addr_d;
      type_q   <= type_d;
      data_q   <= data_d;
      sum_q    <= sum_d;
      chk_q    <= chk_d;
      err_q    <= err_d;
    end
  end

  // Form the result from the current record state
  always_comb begin
    packed_w = '0;
    for (int i = 0; i < MAX_DATA_BYTES; i++) begin
      packed_w[8*i +: 8] = data_q[i];
    end
    res_o.data_count   = taken;
    res_o.load_address = addr_q;
    res_o.record_type  = type_q;
    res_o.data_low     = packed_w[DATA_W-1:0];
    res_o.data_high    = packed_w[2*DATA_W-1:DATA_W];
    res_o.checksum_ok  = (chk_q == 8'(8'd0 - sum_q));
    res_o.format_error = err_q || (count_q > MAX_DATA_BYTES) || (pos_q < rec_end);
  end

  // The digit position never runs past the checksum of the current record
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= rec_end)
    else $error("digit position past end of record");

  // A colon always restarts the record at its first digit
  a_colon_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_i && char_i == CHAR_COLON |=> in_rec_q && pos_q == '0 && !err_q)
    else $error("colon did not restart the record");

  // A line feed closes the record
  a_lf_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !in_rec_q)
    else $error("record still open after line feed");

endmodule

@@ verif/tb_intel_hex_record_parser_core.sv @@
// Testbench for the Intel HEX record parser core: directed and random text against a parser model.
module tb_intel_hex_record_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_BYTES = ihex_pkg::MAX_DATA_BYTES;
  localparam logic [7:0]  LF        = ihex_pkg::CHAR_LF;
  localparam logic [7:0]  CR        = ihex_pkg::CHAR_CR;
  localparam logic [7:0]  COLON     = ihex_pkg::CHAR_COLON;

  // Record types used by name in the stimulus
  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_EXT_LIN = 8'h04;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} data_fill_e;
  typedef enum int {
    FLAW_NONE, FLAW_BAD_SUM, FLAW_SHORT, FLAW_BAD_CHAR, FLAW_TRAILING, FLAW_CR
  } rec_flaw_e;

  typedef struct {
    logic [4:0]  data_count;
    logic [15:0] load_address;
    logic [7:0]  record_type;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic        checksum_ok;
    logic        format_error;
  } hex_record_t;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              cfg_we_i      = 1'b0;
  logic [0:0]                        cfg_wdata_i   = '0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [ihex_pkg::IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [ihex_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;

  // Parser model state
  bit          mdl_word_mode = 1'b1;
  bit          mdl_open      = 1'b0;
  int unsigned mdl_pos       = 0;
  logic [3:0]  mdl_hi_nib    = '0;
  logic [7:0]  mdl_count     = '0;
  logic [15:0] mdl_addr      = '0;
  logic [7:0]  mdl_type      = '0;
  logic [7:0]  mdl_data [16] = '{default: '0};
  logic [7:0]  mdl_sum       = '0;
  logic [7:0]  mdl_csum      = '0;
  bit          mdl_err       = 1'b0;

  hex_record_t pending_records[$];
  int unsigned error_count    = 0;
  int unsigned chars_sent     = 0;
  int unsigned sink_hold_left = 0;
  bit          idle_on        = 1'b1;

  intel_hex_record_parser_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Decode a hex digit of either case; returns 0 for anything else
  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = c[3:0];
      return 1'b1;
    end
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
      v = c[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 4'd10) return 8'h30 + v;
    return (lower ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [3:0] v;
    do c = 8'($urandom);
    while (hex_nibble(c, v) || c == COLON || c == LF || c == CR);
    return c;
  endfunction

  function automatic void clear_model_record();
    mdl_pos    = 0;
    mdl_hi_nib = '0;
    mdl_count  = '0;
    mdl_addr   = '0;
    mdl_type   = '0;
    mdl_data   = '{default: '0};
    mdl_sum    = '0;
    mdl_csum   = '0;
    mdl_err    = 1'b0;
  endfunction

  // Advance the parser model by one accepted character; queue a record on line feed
  function automatic void parse_model_char(input logic [7:0] c);
    logic [3:0]  nib;
    logic [7:0]  val;
    logic [7:0]  neg_sum;
    int unsigned n_data;
    int unsigned data_end;
    hex_record_t rec;
    if (c == COLON) begin
      clear_model_record();
      mdl_open = 1'b1;
      return;
    end
    if (!mdl_open || c == CR) return;
    n_data   = (mdl_count > MAX_BYTES) ? MAX_BYTES : mdl_count;
    data_end = 8 + 2 * n_data;
    if (c == LF) begin
      neg_sum              = 8'h00 - mdl_sum;
      rec.data_count       = 5'(n_data);
      rec.load_address     = mdl_word_mode ? (mdl_addr >> 1) : mdl_addr;
      rec.record_type      = mdl_type;
      for (int i = 0; i < 8; i++) begin
        rec.data_low[8*i +: 8]  = mdl_data[i];
        rec.data_high[8*i +: 8] = mdl_data[i+8];
      end
      rec.checksum_ok  = (mdl_csum == neg_sum);
      rec.format_error = mdl_err || (mdl_count > MAX_BYTES) || (mdl_pos < data_end + 2);
      pending_records.push_back(rec);
      mdl_open = 1'b0;
      return;
    end
    if (!hex_nibble(c, nib)) begin
      mdl_err = 1'b1;
      return;
    end
    // drop digits past the checksum
    if (mdl_pos >= data_end + 2) return;
    if (mdl_pos % 2 == 0) begin
      mdl_hi_nib = nib;
      mdl_pos++;
      return;
    end
    val = {mdl_hi_nib, nib};
    case (mdl_pos)
      1: mdl_count = val;
      3: mdl_addr[15:8] = val;
      5: mdl_addr[7:0] = val;
      7: mdl_type = val;
      default: begin
        if (mdl_pos < data_end) mdl_data[(mdl_pos - 8) / 2] = val;
        else mdl_csum = val;
      end
    endcase
    if (mdl_pos < data_end) mdl_sum = mdl_sum + val;
    mdl_pos++;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Compare one output word with the oldest pending record
  function automatic void check_record(input logic [ihex_pkg::OUT_TDATA_W-1:0] word);
    hex_record_t want;
    if (pending_records.size() == 0) begin
      error_count++;
      $display("%0t: output word with no record pending, actual %0h", $time, word);
      return;
    end
    want = pending_records.pop_front();
    check_field("data_count",   want.data_count,   word[4:0]);
    check_field("load_address", want.load_address, word[20:5]);
    check_field("record_type",  want.record_type,  word[28:21]);
    check_field("data_low",     want.data_low,     word[92:29]);
    check_field("data_high",    want.data_high,    word[156:93]);
    check_field("checksum_ok",  want.checksum_ok,  word[157]);
    check_field("format_error", want.format_error, word[158]);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_record(m_axis_tdata);
  end

  // Drive ready: long holds on request, random stall bursts while idling is on
  initial begin : sink_ready_gen
    int unsigned burst;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        m_axis_tready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 12) begin
        burst = $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one character word, wait for the handshake, then update the model
  task automatic send_char(input logic [7:0] c);
    if (idle_on && $urandom_range(0, 99) < 15) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    parse_model_char(c);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Build one record line with a correct checksum, then apply the requested flaw
  task automatic send_record(input logic [7:0] cnt, input logic [15:0] addr,
                             input logic [7:0] rtype, input data_fill_e fill,
                             input rec_flaw_e flaw);
    logic [7:0]  fields[$];
    logic [7:0]  line[$];
    logic [7:0]  sum;
    int unsigned n_data;
    int unsigned keep;
    n_data = (cnt > MAX_BYTES) ? MAX_BYTES : cnt;
    fields.push_back(cnt);
    fields.push_back(addr[15:8]);
    fields.push_back(addr[7:0]);
    fields.push_back(rtype);
    for (int i = 0; i < n_data; i++) begin
      case (fill)
        FILL_ZERO: fields.push_back(8'h00);
        FILL_ONES: fields.push_back(8'hFF);
        default:   fields.push_back(8'($urandom));
      endcase
    end
    sum = '0;
    foreach (fields[i]) sum = sum + fields[i];
    sum = 8'h00 - sum;
    if (flaw == FLAW_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
    fields.push_back(sum);
    line.push_back(COLON);
    foreach (fields[i]) begin
      line.push_back(hex_char(fields[i][7:4], 1'($urandom_range(0, 1))));
      line.push_back(hex_char(fields[i][3:0], 1'($urandom_range(0, 1))));
    end
    case (flaw)
      FLAW_SHORT: begin
        keep = $urandom_range(1, line.size() - 1);
        while (line.size() > keep) void'(line.pop_back());
      end
      FLAW_BAD_CHAR: line.insert($urandom_range(1, line.size() - 1), non_hex_char());
      FLAW_TRAILING: begin
        repeat ($urandom_range(1, 4))
          line.push_back(hex_char(4'($urandom), 1'($urandom_range(0, 1))));
      end
      FLAW_CR: begin
        line.insert($urandom_range(1, line.size() - 1), CR);
        line.push_back(CR);
      end
      default: ;
    endcase
    line.push_back(LF);
    foreach (line[i]) send_char(line[i]);
  endtask

  task automatic send_random_record(input rec_flaw_e flaw);
    logic [7:0]  cnt;
    logic [7:0]  rtype;
    int unsigned pick;
    // favor short records, with some full and oversize ones
    pick = $urandom_range(0, 9);
    if (pick < 5) cnt = 8'($urandom_range(0, 3));
    else if (pick < 8) cnt = 8'($urandom_range(4, 15));
    else if (pick == 8) cnt = 8'(MAX_BYTES);
    else cnt = 8'($urandom_range(MAX_BYTES + 1, 255));
    pick = $urandom_range(0, 9);
    if (pick < 6) rtype = REC_DATA;
    else if (pick < 8) rtype = REC_EOF;
    else rtype = 8'($urandom);
    send_record(cnt, 16'($urandom), rtype, FILL_RANDOM, flaw);
  endtask

  // Stop offering and let every pending record and any in-flight word drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_word_mode(input bit mode);
    cfg_wdata_i <= mode;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i      <= 1'b0;
    mdl_word_mode = mode;
  endtask

  task automatic test_directed_records();
    idle_on = 1'b1;
    send_record(8'h00, 16'h0000, REC_EOF, FILL_RANDOM, FLAW_NONE);
    send_record(8'h10, 16'hFFFF, REC_DATA, FILL_ONES, FLAW_NONE);
    send_record(8'h10, 16'h0001, REC_DATA, FILL_ZERO, FLAW_CR);
    // oversize counts: only the first sixteen bytes are taken
    send_record(8'h11, 16'h8000, REC_DATA, FILL_RANDOM, FLAW_NONE);
    send_record(8'hFF, 16'h1234, 8'hFF, FILL_ONES, FLAW_NONE);
    send_record(8'h04, 16'hABCD, REC_EXT_LIN, FILL_RANDOM, FLAW_BAD_SUM);
    send_record(8'h02, 16'h0100, REC_DATA, FILL_RANDOM, FLAW_BAD_CHAR);
    send_record(8'h03, 16'h0200, REC_DATA, FILL_RANDOM, FLAW_SHORT);
    send_record(8'h01, 16'h0300, REC_DATA, FILL_RANDOM, FLAW_TRAILING);
    // text outside a record is ignored, a bare line feed gives nothing
    send_text("junk\r\n");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(LF);
    // colon inside a record restarts it
    send_text(":0102");
    send_record(8'h00, 16'h0000, REC_EOF, FILL_RANDOM, FLAW_NONE);
    send_text(":\n");
    send_text(":1\n");
    send_text(":00000001ff\n");
    send_text(":0G0000001FF\n");
    wait_idle();
  endtask

  task automatic test_word_address_mode();
    write_word_mode(1'b0);
    send_record(8'h02, 16'hFFFF, REC_DATA, FILL_RANDOM, FLAW_NONE);
    send_record(8'h01, 16'h0001, REC_DATA, FILL_RANDOM, FLAW_NONE);
    send_record(8'h00, 16'($urandom), REC_EOF, FILL_RANDOM, FLAW_NONE);
    wait_idle();
    write_word_mode(1'b1);
    send_record(8'h02, 16'hFFFF, REC_DATA, FILL_RANDOM, FLAW_NONE);
    send_record(8'h01, 16'h0001, REC_DATA, FILL_RANDOM, FLAW_NONE);
    wait_idle();
  endtask

  // Hold the output off while records keep coming so the input side stalls
  task automatic test_output_stall();
    idle_on        = 1'b1;
    sink_hold_left = 400;
    repeat (8)
      send_record(8'($urandom_range(0, 2)), 16'($urandom), REC_DATA, FILL_RANDOM, FLAW_NONE);
    wait_idle();
  endtask

  task automatic test_random_stream();
    int unsigned goal;
    int unsigned pick;
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      write_word_mode(1'($urandom_range(0, 1)));
      idle_on = (phase % 4 != 3);
      goal    = chars_sent + 75;
      while (chars_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) send_random_record(FLAW_NONE);
        else if (pick < 85) send_random_record(rec_flaw_e'($urandom_range(FLAW_BAD_SUM, FLAW_CR)));
        else repeat ($urandom_range(1, 6)) send_char(8'($urandom));
      end
    end
    wait_idle();
  endtask

  task automatic test_steady_tail();
    int unsigned goal;
    idle_on = 1'b0;
    goal    = chars_sent + 150;
    while (chars_sent < goal) send_random_record(FLAW_NONE);
    wait_idle();
  endtask

  initial begin
    clear_model_record();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_records();
    test_word_address_mode();
    test_output_stall();
    test_random_stream();
    test_steady_tail();
    repeat (6) @(posedge clk_i);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
